// ===== sv/tgcs_pkg.sv =====
`default_nettype none

package tgcs_pkg;

   localparam int ROW_COUNT_DEF = 24;
   localparam int COL_COUNT_DEF = 80;

   localparam logic [7:0] CHAR_BLANK = 8'h20;
   localparam logic [7:0] CHAR_DEL   = 8'h7f;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   localparam int TAB_STOP = 8;

   localparam logic MODE_PUT  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_PRINT,
      OP_CR,
      OP_LF,
      OP_BS,
      OP_TAB,
      OP_NOP,
      OP_READ,
      OP_READ_NONE
   } op_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
      logic [7:0] read_char;
      logic       scrolled;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic [4:0] row;
      logic [6:0] col;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_INIT   = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_READ   = 4'b0100,
      ST_SCROLL = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== sv/text_grid_cursor_scroll.sv =====
// A word reaches the result port through the command queue and the result register;
// a read also passes the registered cell memory and the read state, and a scroll
// first sweeps the new bottom row one cell a cycle. The back end takes one word per
// cycle while the result register is free, and none while it reads or scrolls.
// Reset: synchronous, clears cursor and row pointer, then blanks all
// ROW_COUNT * COL_COUNT cells, one per cycle, with req_ready held low.
`default_nettype none

module text_grid_cursor_scroll #(
   parameter int ROW_COUNT = tgcs_pkg::ROW_COUNT_DEF,
   parameter int COL_COUNT = tgcs_pkg::COL_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tgcs_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tgcs_pkg::rsp_type      rsp_payload
);

   // Front end: classify the incoming word into a command (control byte,
   // printable byte, in-range or out-of-range read) and push it.
   logic              push_valid;
   tgcs_pkg::cmd_type push_cmd;
   logic              queue_full;
   logic              back_busy;

   // Queue: two commands deep, so the front keeps taking words while the
   // back end reads a cell or sweeps a row during a scroll.
   logic              q_valid;
   logic              q_pop;
   tgcs_pkg::cmd_type q_cmd;

   tgcs_front #(
      .ROW_COUNT (ROW_COUNT),
      .COL_COUNT (COL_COUNT)
   ) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .back_busy   (back_busy),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   tgcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd)
   );

   // Back end: owns the cursor, the cell memory and the result register.
   // The grid is a ring of rows: a scroll advances the top-row pointer and
   // blanks the row that wrapped around, so no row is ever copied.
   tgcs_back #(
      .ROW_COUNT (ROW_COUNT),
      .COL_COUNT (COL_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .q_pop       (q_pop),
      .busy        (back_busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== sv/tgcs_front.sv =====
`default_nettype none

module tgcs_front #(
   parameter int ROW_COUNT = tgcs_pkg::ROW_COUNT_DEF,
   parameter int COL_COUNT = tgcs_pkg::COL_COUNT_DEF
) (
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tgcs_pkg::req_type req_payload,
   input  wire logic             queue_full,
   input  wire logic             back_busy,
   output logic                  push_valid,
   output tgcs_pkg::cmd_type     push_cmd
);

   logic in_range;

   // Hold off during the clearing pass and while the queue is full.
   assign req_ready  = !queue_full && !back_busy;
   assign push_valid = req_valid && req_ready;

   assign in_range = (32'(req_payload.read_row) < ROW_COUNT) &&
                     (32'(req_payload.read_col) < COL_COUNT);

   always_comb begin
      push_cmd.data = req_payload.data_byte;
      push_cmd.row  = req_payload.read_row;
      push_cmd.col  = req_payload.read_col;
      if (req_payload.mode == tgcs_pkg::MODE_READ) begin
         push_cmd.op = in_range ? tgcs_pkg::OP_READ : tgcs_pkg::OP_READ_NONE;
      end else begin
         priority if (req_payload.data_byte == tgcs_pkg::CHAR_CR) begin
            push_cmd.op = tgcs_pkg::OP_CR;
         end else if (req_payload.data_byte == tgcs_pkg::CHAR_LF) begin
            push_cmd.op = tgcs_pkg::OP_LF;
         end else if (req_payload.data_byte == tgcs_pkg::CHAR_BS) begin
            push_cmd.op = tgcs_pkg::OP_BS;
         end else if (req_payload.data_byte == tgcs_pkg::CHAR_TAB) begin
            push_cmd.op = tgcs_pkg::OP_TAB;
         end else if (req_payload.data_byte < tgcs_pkg::CHAR_BLANK ||
                      req_payload.data_byte == tgcs_pkg::CHAR_DEL) begin
            push_cmd.op = tgcs_pkg::OP_NOP;
         end else begin
            push_cmd.op = tgcs_pkg::OP_PRINT;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/tgcs_queue.sv =====
`default_nettype none

module tgcs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire tgcs_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output tgcs_pkg::cmd_type      pop_cmd
);

   tgcs_pkg::cmd_type entry_ff [tgcs_pkg::QUEUE_DEPTH];

   logic [tgcs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tgcs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tgcs_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign full      = count_ff == tgcs_pkg::QCNT_W'(tgcs_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == tgcs_pkg::QUEUE_DEPTH - 1) ? '0
                     : wr_ptr_ff + tgcs_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == tgcs_pkg::QUEUE_DEPTH - 1) ? '0
                     : rd_ptr_ff + tgcs_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + tgcs_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - tgcs_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== sv/tgcs_back.sv =====
`default_nettype none

module tgcs_back #(
   parameter int ROW_COUNT = tgcs_pkg::ROW_COUNT_DEF,
   parameter int COL_COUNT = tgcs_pkg::COL_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire tgcs_pkg::cmd_type q_cmd,
   output logic                   q_pop,
   output logic                   busy,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tgcs_pkg::rsp_type      rsp_payload
);

   localparam int CELL_COUNT = ROW_COUNT * COL_COUNT;
   localparam int RW = $clog2(ROW_COUNT);
   localparam int CW = $clog2(COL_COUNT + 1);
   localparam int AW = $clog2(CELL_COUNT);
   localparam logic [AW-1:0] COLS_A = AW'(COL_COUNT);

   // Map a screen row through the rotating top pointer to a cell address.
   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                               input logic [RW-1:0] top,
                                               input logic [CW-1:0] col);
      logic [RW:0] sum;
      logic [RW:0] phys;
      sum  = {1'b0, row} + {1'b0, top};
      phys = (32'(sum) >= ROW_COUNT) ? sum - (RW+1)'(ROW_COUNT) : sum;
      return AW'(phys[RW-1:0]) * COLS_A + AW'(col);
   endfunction

   logic [7:0] cells [CELL_COUNT];

   tgcs_pkg::state_type state_ff, state_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       top_ff, top_in;
   logic [AW-1:0]       init_addr_ff, init_addr_in;
   logic [AW-1:0]       sweep_addr_ff, sweep_addr_in;
   logic [CW-1:0]       sweep_col_ff, sweep_col_in;
   logic                pend_print_ff, pend_print_in;
   logic [7:0]          pend_byte_ff, pend_byte_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tgcs_pkg::rsp_type   rsp_ff, rsp_in;
   logic [7:0]          rd_data_ff;

   logic          we;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;
   logic [AW-1:0] raddr;

   logic          out_free;
   logic          load_rsp;
   logic [7:0]    load_char;
   logic          load_scrolled;
   logic          wrap;
   logic          at_bottom;
   logic [RW-1:0] print_row;
   logic [CW-1:0] print_col;
   logic [CW:0]   tab_sum;
   logic [CW:0]   tab_next;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign busy        = state_ff == tgcs_pkg::ST_INIT;
   assign q_pop       = (state_ff == tgcs_pkg::ST_IDLE) && q_valid && out_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign wrap      = col_ff == CW'(COL_COUNT);
   assign at_bottom = row_ff == RW'(ROW_COUNT - 1);
   assign print_row = wrap ? row_ff + RW'(1) : row_ff;
   assign print_col = wrap ? '0 : col_ff;
   assign tab_sum   = {1'b0, col_ff} + (CW+1)'(tgcs_pkg::TAB_STOP);
   assign tab_next  = tab_sum & ~(CW+1)'(tgcs_pkg::TAB_STOP - 1);
   assign raddr     = cell_addr(RW'(q_cmd.row), top_ff, CW'(q_cmd.col));

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      top_in        = top_ff;
      init_addr_in  = init_addr_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_col_in  = sweep_col_ff;
      pend_print_in = pend_print_ff;
      pend_byte_in  = pend_byte_ff;
      we            = 1'b0;
      waddr         = sweep_addr_ff;
      wdata         = tgcs_pkg::CHAR_BLANK;
      load_rsp      = 1'b0;
      load_char     = '0;
      load_scrolled = 1'b0;

      unique case (state_ff)
         tgcs_pkg::ST_INIT: begin
            // Blank every cell once after reset.
            we           = 1'b1;
            waddr        = init_addr_ff;
            init_addr_in = init_addr_ff + AW'(1);
            if (init_addr_ff == AW'(CELL_COUNT - 1)) begin
               state_in = tgcs_pkg::ST_IDLE;
            end
         end
         tgcs_pkg::ST_IDLE: begin
            if (q_pop) begin
               unique case (q_cmd.op)
                  tgcs_pkg::OP_CR: begin
                     col_in   = '0;
                     load_rsp = 1'b1;
                  end
                  tgcs_pkg::OP_LF: begin
                     col_in = '0;
                     if (at_bottom) begin
                        pend_print_in = 1'b0;
                        state_in      = tgcs_pkg::ST_SCROLL;
                     end else begin
                        row_in   = row_ff + RW'(1);
                        load_rsp = 1'b1;
                     end
                  end
                  tgcs_pkg::OP_BS: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - CW'(1);
                     end
                     load_rsp = 1'b1;
                  end
                  tgcs_pkg::OP_TAB: begin
                     col_in   = (32'(tab_next) > COL_COUNT) ? CW'(COL_COUNT)
                                : CW'(tab_next);
                     load_rsp = 1'b1;
                  end
                  tgcs_pkg::OP_NOP: begin
                     load_rsp = 1'b1;
                  end
                  tgcs_pkg::OP_PRINT: begin
                     if (wrap && at_bottom) begin
                        // Byte lands in column 0 of the fresh bottom row.
                        col_in        = '0;
                        pend_print_in = 1'b1;
                        pend_byte_in  = q_cmd.data;
                        state_in      = tgcs_pkg::ST_SCROLL;
                     end else begin
                        we       = 1'b1;
                        waddr    = cell_addr(print_row, top_ff, print_col);
                        wdata    = q_cmd.data;
                        row_in   = print_row;
                        col_in   = print_col + CW'(1);
                        load_rsp = 1'b1;
                     end
                  end
                  tgcs_pkg::OP_READ: begin
                     state_in = tgcs_pkg::ST_READ;
                  end
                  tgcs_pkg::OP_READ_NONE: begin
                     load_rsp = 1'b1;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
               if (state_in == tgcs_pkg::ST_SCROLL) begin
                  // Old top row becomes the new bottom row.
                  top_in        = (top_ff == RW'(ROW_COUNT - 1)) ? '0
                                  : top_ff + RW'(1);
                  sweep_addr_in = AW'(top_ff) * COLS_A;
                  sweep_col_in  = '0;
               end
            end
         end
         tgcs_pkg::ST_READ: begin
            load_rsp  = 1'b1;
            load_char = rd_data_ff;
            state_in  = tgcs_pkg::ST_IDLE;
         end
         tgcs_pkg::ST_SCROLL: begin
            we            = 1'b1;
            waddr         = sweep_addr_ff;
            wdata         = (pend_print_ff && sweep_col_ff == '0) ? pend_byte_ff
                            : tgcs_pkg::CHAR_BLANK;
            sweep_addr_in = sweep_addr_ff + AW'(1);
            sweep_col_in  = sweep_col_ff + CW'(1);
            if (sweep_col_ff == CW'(COL_COUNT - 1)) begin
               col_in        = pend_print_ff ? CW'(1) : '0;
               load_rsp      = 1'b1;
               load_scrolled = 1'b1;
               state_in      = tgcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tgcs_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (load_rsp) begin
         rsp_valid_in         = 1'b1;
         rsp_in.cursor_row    = 5'(row_in);
         rsp_in.cursor_col    = 7'(col_in);
         rsp_in.read_char     = load_char;
         rsp_in.scrolled      = load_scrolled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tgcs_pkg::ST_INIT;
         row_ff        <= '0;
         col_ff        <= '0;
         top_ff        <= '0;
         init_addr_ff  <= '0;
         pend_print_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         top_ff        <= top_in;
         init_addr_ff  <= init_addr_in;
         pend_print_ff <= pend_print_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_addr_ff <= sweep_addr_in;
      sweep_col_ff  <= sweep_col_in;
      pend_byte_ff  <= pend_byte_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         cells[waddr] <= wdata;
      end
      rd_data_ff <= cells[raddr];
   end

endmodule

`default_nettype wire

// ===== tb/tb_text_grid_cursor_scroll.sv =====
`default_nettype none

module tb_text_grid_cursor_scroll;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_COUNT = tgcs_pkg::ROW_COUNT_DEF;
   localparam int COL_COUNT = tgcs_pkg::COL_COUNT_DEF;
   // Longest quiet stretch: the blanking pass after reset, a scroll sweep,
   // plus the longest sender gap and receiver stall, taken several times over.
   localparam int WATCHDOG_LIMIT = 4 * (ROW_COUNT * COL_COUNT + COL_COUNT + 200);

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   tgcs_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   tgcs_pkg::rsp_type rsp_payload;

   text_grid_cursor_scroll #(
      .ROW_COUNT(ROW_COUNT),
      .COL_COUNT(COL_COUNT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow terminal: screen contents and cursor as the block should hold them.
   logic [7:0]  screen [ROW_COUNT][COL_COUNT];
   int unsigned cur_row;
   int unsigned cur_col;

   // Cursor/cell results still owed by the block, oldest first.
   tgcs_pkg::rsp_type awaited_rsp [$];

   int          err_count;
   int          words_taken;
   int          rsp_checked;
   int          scroll_count;
   int          quiet_cycles;
   bit          sender_gaps = 1'b1;
   int          stall_left;
   int          ready_run;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void blank_screen();
      foreach (screen[r, c]) screen[r][c] = tgcs_pkg::CHAR_BLANK;
      cur_row = 0;
      cur_col = 0;
   endfunction

   // Shift every row up, blank the bottom one, park the cursor on it.
   function automatic void roll_screen();
      for (int r = 0; r < ROW_COUNT - 1; r++)
         for (int c = 0; c < COL_COUNT; c++)
            screen[r][c] = screen[r + 1][c];
      for (int c = 0; c < COL_COUNT; c++)
         screen[ROW_COUNT - 1][c] = tgcs_pkg::CHAR_BLANK;
      cur_row = ROW_COUNT - 1;
   endfunction

   // Apply one accepted word to the shadow terminal and return what the block owes.
   function automatic tgcs_pkg::rsp_type terminal_step(input tgcs_pkg::req_type w);
      tgcs_pkg::rsp_type r;
      int unsigned       nxt;
      r = '0;
      if (w.mode == tgcs_pkg::MODE_PUT) begin
         unique case (w.data_byte)
            tgcs_pkg::CHAR_CR: cur_col = 0;
            tgcs_pkg::CHAR_LF: begin
               cur_col = 0;
               cur_row++;
               if (cur_row >= ROW_COUNT) begin
                  roll_screen();
                  r.scrolled = 1'b1;
               end
            end
            tgcs_pkg::CHAR_BS: if (cur_col > 0) cur_col--;
            tgcs_pkg::CHAR_TAB: begin
               // Advance to the next tab stop, saturating at the right edge.
               nxt     = (cur_col + tgcs_pkg::TAB_STOP) & ~(tgcs_pkg::TAB_STOP - 1);
               cur_col = (nxt > COL_COUNT) ? COL_COUNT : nxt;
            end
            default: begin
               if (w.data_byte >= tgcs_pkg::CHAR_BLANK &&
                   w.data_byte != tgcs_pkg::CHAR_DEL) begin
                  // Take a pending wrap first, then scroll if we fell off the bottom.
                  if (cur_col >= COL_COUNT) begin
                     cur_col = 0;
                     cur_row++;
                  end
                  if (cur_row >= ROW_COUNT) begin
                     roll_screen();
                     r.scrolled = 1'b1;
                  end
                  screen[cur_row][cur_col] = w.data_byte;
                  cur_col++;
               end
            end
         endcase
      end else if (w.read_row < ROW_COUNT && w.read_col < COL_COUNT) begin
         r.read_char = screen[w.read_row][w.read_col];
      end
      r.cursor_row = 5'(cur_row);
      r.cursor_col = 7'(cur_col);
      return r;
   endfunction

   function automatic void match_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   // Predict on every accepted input word, check every accepted result word,
   // and watch for a stretch in which nothing moves.
   always @(posedge clock) begin
      tgcs_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            awaited_rsp.push_back(terminal_step(req_payload));
            words_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("result word with nothing expected: %h", rsp_payload);
               err_count++;
            end else begin
               want = awaited_rsp.pop_front();
               match_field("cursor_row", 8'(want.cursor_row), 8'(rsp_payload.cursor_row));
               match_field("cursor_col", 8'(want.cursor_col), 8'(rsp_payload.cursor_col));
               match_field("read_char", want.read_char, rsp_payload.read_char);
               match_field("scrolled", 8'(want.scrolled), 8'(rsp_payload.scrolled));
               if (want.scrolled) scroll_count++;
               rsp_checked++;
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("text_grid_cursor_scroll verification failed");
            $finish;
         end
      end
   end

   // Receiver back-pressure: mostly short stalls, a few long ones,
   // and now and then a long stretch that never stalls.
   always @(posedge clock) begin
      int len;
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (ready_run > 0) begin
         rsp_ready <= 1'b1;
         ready_run--;
      end else if ($urandom_range(0, 15) == 0) begin
         rsp_ready <= 1'b1;
         ready_run = $urandom_range(20, 200);
      end else begin
         len = pick_gap();
         rsp_ready <= (len == 0);
         if (len > 0) stall_left = len - 1;
      end
   end

   // Offer one word and hold it until taken. Valid stays up when the next
   // word follows back to back; drop it only when a gap is inserted.
   task automatic send_word(input tgcs_pkg::req_type w);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic put_byte(input logic [7:0] b);
      tgcs_pkg::req_type w;
      w.mode      = tgcs_pkg::MODE_PUT;
      w.data_byte = b;
      w.read_row  = 5'($urandom);
      w.read_col  = 7'($urandom);
      send_word(w);
   endtask

   task automatic read_cell(input int unsigned row, input int unsigned col);
      tgcs_pkg::req_type w;
      w.mode      = tgcs_pkg::MODE_READ;
      w.data_byte = 8'($urandom);
      w.read_row  = 5'(row);
      w.read_col  = 7'(col);
      send_word(w);
   endtask

   // Hold the sender until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   // Fresh screen is all blanks; out-of-range reads return zero.
   task automatic test_reset_state();
      read_cell(0, 0);
      read_cell(ROW_COUNT - 1, COL_COUNT - 1);
      read_cell(ROW_COUNT, 0);
      read_cell(0, COL_COUNT);
      read_cell(31, 127);
   endtask

   // Every byte class: printable low/high, DEL and other ignored controls,
   // backspace, tab, carriage return, line feed.
   task automatic test_cursor_controls();
      put_byte(8'h41);
      put_byte(8'hff);
      put_byte(8'h80);
      put_byte(tgcs_pkg::CHAR_BLANK);
      put_byte(8'h7e);
      put_byte(tgcs_pkg::CHAR_DEL);
      put_byte(8'h00);
      put_byte(8'h1f);
      put_byte(tgcs_pkg::CHAR_BS);
      put_byte(tgcs_pkg::CHAR_TAB);
      put_byte(tgcs_pkg::CHAR_CR);
      put_byte(tgcs_pkg::CHAR_LF);
      read_cell(0, 0);
      read_cell(0, 1);
   endtask

   // Right edge: tab up to the edge, backspace off a pending wrap,
   // tab saturating at the edge, and a print that takes the wrap.
   task automatic test_right_edge();
      repeat (COL_COUNT / tgcs_pkg::TAB_STOP - 1) put_byte(tgcs_pkg::CHAR_TAB);
      put_byte(8'h2e);
      put_byte(tgcs_pkg::CHAR_TAB);
      put_byte(tgcs_pkg::CHAR_TAB);
      put_byte(tgcs_pkg::CHAR_BS);
      put_byte(8'h78);
      put_byte(tgcs_pkg::CHAR_TAB);
      put_byte(tgcs_pkg::CHAR_BS);
      put_byte(8'h79);
      put_byte(8'h7a);
      read_cell(1, COL_COUNT - 1);
      read_cell(2, 0);
   endtask

   // Bottom row: line feeds past the last row scroll, and so does a
   // wrapping print on the bottom row.
   task automatic test_bottom_scroll();
      repeat (ROW_COUNT) put_byte(tgcs_pkg::CHAR_LF);
      put_byte(8'h71);
      put_byte(tgcs_pkg::CHAR_LF);
      read_cell(ROW_COUNT - 2, 0);
      repeat (COL_COUNT / tgcs_pkg::TAB_STOP) put_byte(tgcs_pkg::CHAR_TAB);
      put_byte(8'h51);
      read_cell(ROW_COUNT - 1, 0);
      read_cell(ROW_COUNT - 3, 0);
   endtask

   // Text-like stream: lines of random length and content, mostly printable
   // with some tabs, backspaces and stray controls, ended by CR/LF variants,
   // with reads of random cells sprinkled in.
   task automatic test_random_text(input int words);
      int         sent;
      int         len;
      int         r;
      logic [7:0] ch;
      sent = 0;
      while (sent < words) begin
         sender_gaps = ($urandom_range(0, 5) != 0);
         r = $urandom_range(0, 9);
         if (r < 6)      len = $urandom_range(0, 40);
         else if (r < 9) len = $urandom_range(41, COL_COUNT);
         else            len = $urandom_range(COL_COUNT + 1, 2 * COL_COUNT + 10);
         for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 80)      ch = 8'($urandom_range(8'h21, 8'h7e));
            else if (r < 86) ch = tgcs_pkg::CHAR_BLANK;
            else if (r < 91) ch = 8'($urandom_range(8'h80, 8'hff));
            else if (r < 95) ch = tgcs_pkg::CHAR_TAB;
            else if (r < 98) ch = tgcs_pkg::CHAR_BS;
            else             ch = 8'($urandom_range(8'h00, 8'h1f));
            put_byte(ch);
            sent++;
            if ($urandom_range(0, 9) == 0) begin
               read_cell($urandom_range(0, ROW_COUNT - 1), $urandom_range(0, COL_COUNT - 1));
               sent++;
            end
         end
         r = $urandom_range(0, 9);
         if (r < 5) begin
            put_byte(tgcs_pkg::CHAR_CR);
            put_byte(tgcs_pkg::CHAR_LF);
            sent += 2;
         end else if (r < 8) begin
            put_byte(tgcs_pkg::CHAR_LF);
            sent++;
         end else if (r < 9) begin
            put_byte(tgcs_pkg::CHAR_CR);
            sent++;
         end
      end
      sender_gaps = 1'b1;
   endtask

   // Raw words: any mode, any byte, any read coordinate including out of range.
   task automatic test_random_noise(input int words);
      tgcs_pkg::req_type w;
      for (int k = 0; k < words; k++) begin
         w.mode      = 1'($urandom);
         w.data_byte = 8'($urandom);
         if ($urandom_range(0, 3) != 0) begin
            w.read_row = 5'($urandom_range(0, ROW_COUNT - 1));
            w.read_col = 7'($urandom_range(0, COL_COUNT - 1));
         end else begin
            w.read_row = 5'($urandom);
            w.read_col = 7'($urandom);
         end
         send_word(w);
      end
   endtask

   initial begin
      blank_screen();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_cursor_controls();
      test_right_edge();
      test_bottom_scroll();
      drain_results();
      test_random_text(700);
      drain_results();
      test_random_noise(300);
      test_random_text(550);

      // Stop offering words, wait out every owed result, then keep the clock
      // running so that anything stray can show up.
      drain_results();
      repeat (COL_COUNT + 8) @(posedge clock);

      $display("Sent %0d words (directed edge cases, text streams, raw noise);",
               words_taken);
      $display("checked %0d result words, %0d of them scrolls.", rsp_checked, scroll_count);
      if (err_count == 0 && awaited_rsp.size() == 0) begin
         $display("text_grid_cursor_scroll verification clean");
      end else begin
         $display("text_grid_cursor_scroll verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
